// ===== hdl/rxot_pkg.sv =====
// ----------------------------------------------------------------------------
// rxot_pkg
// Shared types, codes and helper functions for the rotational-XOR offset
// table sorter.
// ----------------------------------------------------------------------------
package rxot_pkg;

  // Item actions
  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CFG  = 2'd1;
  localparam logic [1:0] ST_BAD_RANK = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ROT_AMOUNT = 3'd0;
  localparam logic [2:0] CFG_WORD_BITS  = 3'd1;
  localparam logic [2:0] CFG_EK_NONE    = 3'd2;
  localparam logic [2:0] CFG_EK_RIGHT   = 3'd3;
  localparam logic [2:0] CFG_EK_LEFT    = 3'd4;
  localparam logic [2:0] CFG_EK_BOTH    = 3'd5;

  // Configuration reset values (Q8.8 weights: 1.414 and 3.0)
  localparam logic [5:0]  ROT_RESET   = 6'd1;
  localparam logic [6:0]  WORD_RESET  = 7'd64;
  localparam logic [15:0] EK_LO_RESET = 16'd362;
  localparam logic [15:0] EK_HI_RESET = 16'd768;

  localparam int WEIGHT_W = 17;
  localparam int FIELD_W  = 11;

  typedef struct packed {
    logic [5:0]  rot_amount;
    logic [6:0]  word_bits;
    logic [15:0] ek_none;
    logic [15:0] ek_right;
    logic [15:0] ek_left;
    logic [15:0] ek_both;
  } cfg_t;

  // Generation phases, in table order
  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_U    = 2'd1,
    PH_V    = 2'd2,
    PH_UV   = 2'd3
  } gen_phase_t;

  typedef struct packed {
    gen_phase_t phase;
    logic [5:0] a;
    logic [5:0] b;
  } entry_req_t;

  // Mask of len = i+1 low ones
  function automatic logic [63:0] low_ones(input logic [5:0] i);
    return {64{1'b1}} >> (6'd63 - i);
  endfunction

  // Integer weight of mask i out of len masks
  function automatic logic [6:0] mask_weight(input logic [5:0] i, input logic [6:0] len);
    logic [6:0] ip1;
    ip1 = {1'b0, i} + 7'd1;
    return (ip1 < len) ? ip1 : len - 7'd1;
  endfunction

endpackage

// ===== hdl/rxot_in_if.sv =====
// ----------------------------------------------------------------------------
// rxot_in_if
// Input item channel: action and rank with valid/ready.
// ----------------------------------------------------------------------------
interface rxot_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [10:0] rank;

  modport source (output valid, output action, output rank, input ready);
  modport sink   (input valid, input action, input rank, output ready);
endinterface

// ===== hdl/rxot_out_if.sv =====
// ----------------------------------------------------------------------------
// rxot_out_if
// Result item channel: table entry fields and status with valid/ready.
// ----------------------------------------------------------------------------
interface rxot_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] offset_value;
  logic [16:0] weight;
  logic [10:0] source_index;
  logic [10:0] entry_total;
  logic [1:0]  status;

  modport source (output valid, output offset_value, output weight, output source_index,
                  output entry_total, output status, input ready);
  modport sink   (input valid, input offset_value, input weight, input source_index,
                  input entry_total, input status, output ready);
endinterface

// ===== hdl/rxot_entry_gen.sv =====
// ----------------------------------------------------------------------------
// rxot_entry_gen
// Offset mask and Q9.8 weight of one table entry from its generation
// position (phase, u index a, v index b).
// ----------------------------------------------------------------------------
module rxot_entry_gen (
  input  rxot_pkg::entry_req_t req,
  input  rxot_pkg::cfg_t       cfg,
  output logic [63:0]          mask,
  output logic [16:0]          weight
);
  import rxot_pkg::*;

  logic [6:0]  m_len;
  logic [6:0]  wu;
  logic [6:0]  wv;
  logic [63:0] u_mask;
  logic [63:0] v_mask;
  logic [15:0] ek_sel;
  logic [7:0]  int_w;

  assign m_len  = cfg.word_bits - {1'b0, cfg.rot_amount};
  assign wu     = mask_weight(req.a, {1'b0, cfg.rot_amount});
  assign wv     = mask_weight(req.b, m_len);
  assign u_mask = low_ones(req.a);
  assign v_mask = low_ones(req.b) << cfg.rot_amount;

  // Select mask, Ek and integer weight by phase
  always_comb begin
    case (req.phase)
      PH_ZERO: begin
        mask = '0; ek_sel = cfg.ek_none; int_w = '0;
      end
      PH_U: begin
        mask = u_mask; ek_sel = cfg.ek_right; int_w = {1'b0, wu};
      end
      PH_V: begin
        mask = v_mask; ek_sel = cfg.ek_left; int_w = {1'b0, wv};
      end
      PH_UV: begin
        mask = v_mask ^ u_mask; ek_sel = cfg.ek_both; int_w = {1'b0, wu} + {1'b0, wv};
      end
      default: begin
        mask = '0; ek_sel = cfg.ek_none; int_w = '0;
      end
    endcase
  end

  assign weight = {1'b0, ek_sel} + {1'b0, int_w, 8'h00};

endmodule

// ===== hdl/rx_xor_offset_table_sorter.sv =====
// ----------------------------------------------------------------------------
// rx_xor_offset_table_sorter
// Builds the rotational-XOR offset table, sorts it by weight and reads
// entries back by rank.
// ----------------------------------------------------------------------------
// Usage:
//   Configure rotation, word size and the four Ek weights through the cfg_
//   write port while the block is idle. An action-0 item builds and sorts the
//   table; an action-1 item reads the entry at the given rank. Each item gives
//   exactly one result item on out_ch.
// Read and build sequence:
//   A read passes through the weight/index memory read, the offset memory
//   read and result staging before its result is loaded into the output
//   register; the next item is taken only once the block is back in idle.
//   A build generates the N entries (N = 1 + n + k(n-k)) in table order,
//   then runs a selection sort: pass i streams entries i..N-1 through the
//   single weight/index memory read port and swaps with two writes. A bad
//   configuration returns status at once and leaves the old table in place.
// Reset and stalls:
//   Reset clears the state machine, the build and entry counts and the
//   table-ready flag; the memories need no clearing. A result waits in the
//   output register while out_ch.ready is low; the next item may still be
//   accepted and its result is held until the register frees up.
// ----------------------------------------------------------------------------
module rx_xor_offset_table_sorter #(
  parameter int TABLE_DEPTH = 2048,
  parameter int MAX_WORD    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rxot_in_if.sink    in_ch,
  rxot_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rxot_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = WEIGHT_W + IW;
  localparam int RW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int SW = (IW > FIELD_W) ? IW : FIELD_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [7:0]    MAXW_C  = 8'(MAX_WORD);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_GEN    = 10'b0000000010,
    S_SORT0  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_SWAP_A = 10'b0000010000,
    S_SWAP_B = 10'b0000100000,
    S_FIN    = 10'b0001000000,
    S_RD_WI  = 10'b0010000000,
    S_RD_OFF = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

  // Registers
  cfg_t            cfg_r;
  state_t          state_r, state_nxt;
  entry_req_t      req_r, req_nxt;
  logic [CW-1:0]   build_cnt_r, build_cnt_nxt;
  logic [CW-1:0]   entry_count_r, entry_count_nxt;
  logic            ready_r, ready_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   q_r, q_nxt;
  logic [IW-1:0]   p_r, p_nxt;
  logic            pend_r, pend_nxt;
  logic [WW-1:0]   best_r, best_nxt;
  logic [WW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   bidx_r, bidx_nxt;
  logic [63:0]     res_off_r, res_off_nxt;
  logic [16:0]     res_w_r, res_w_nxt;
  logic [10:0]     res_src_r, res_src_nxt;
  logic [10:0]     res_total_r, res_total_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_off_r, out_off_nxt;
  logic [16:0]     out_w_r, out_w_nxt;
  logic [10:0]     out_src_r, out_src_nxt;
  logic [10:0]     out_total_r, out_total_nxt;
  logic [1:0]      out_st_r, out_st_nxt;

  // Memories
  logic [63:0]     off_mem [TABLE_DEPTH];
  logic [WW-1:0]   wi_mem  [TABLE_DEPTH];
  logic [63:0]     off_rdata;
  logic [WW-1:0]   wi_rdata;
  logic            off_we, off_re, wi_we, wi_re;
  logic [IW-1:0]   off_waddr, off_raddr, wi_waddr, wi_raddr;
  logic [WW-1:0]   wi_wdata;

  // Entry generator
  logic [63:0]     gen_mask;
  logic [16:0]     gen_weight;

  logic            in_fire;
  logic            cfg_bad;
  logic [5:0]      k_m1;
  logic [5:0]      m_m1;
  logic [RW-1:0]   rank_x;
  logic [RW-1:0]   count_x;
  logic [SW-1:0]   src_x;
  logic [RW-1:0]   total_x;
  logic            out_free;

  rxot_entry_gen u_gen (
    .req    (req_r),
    .cfg    (cfg_r),
    .mask   (gen_mask),
    .weight (gen_weight)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_amount <= ROT_RESET;
      cfg_r.word_bits  <= WORD_RESET;
      cfg_r.ek_none    <= EK_LO_RESET;
      cfg_r.ek_right   <= EK_LO_RESET;
      cfg_r.ek_left    <= EK_HI_RESET;
      cfg_r.ek_both    <= EK_HI_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROT_AMOUNT: cfg_r.rot_amount <= cfg_wdata[5:0];
        CFG_WORD_BITS:  cfg_r.word_bits  <= cfg_wdata[6:0];
        CFG_EK_NONE:    cfg_r.ek_none    <= cfg_wdata;
        CFG_EK_RIGHT:   cfg_r.ek_right   <= cfg_wdata;
        CFG_EK_LEFT:    cfg_r.ek_left    <= cfg_wdata;
        CFG_EK_BOTH:    cfg_r.ek_both    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_bad     = (cfg_r.rot_amount == 6'd0) ||
                       ({1'b0, cfg_r.rot_amount} >= cfg_r.word_bits) ||
                       ({1'b0, cfg_r.word_bits} > MAXW_C);
  assign k_m1        = cfg_r.rot_amount - 6'd1;
  assign m_m1        = 6'(cfg_r.word_bits - {1'b0, cfg_r.rot_amount} - 7'd1);
  assign rank_x      = RW'(in_ch.rank);
  assign count_x     = RW'(entry_count_r);
  assign src_x       = SW'(wi_rdata[IW-1:0]);
  assign total_x     = RW'(build_cnt_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Control sequencer
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    build_cnt_nxt   = build_cnt_r;
    entry_count_nxt = entry_count_r;
    ready_nxt       = ready_r;
    i_nxt           = i_r;
    q_nxt           = q_r;
    p_nxt           = p_r;
    pend_nxt        = pend_r;
    best_nxt        = best_r;
    cur_nxt         = cur_r;
    bidx_nxt        = bidx_r;
    res_off_nxt     = res_off_r;
    res_w_nxt       = res_w_r;
    res_src_nxt     = res_src_r;
    res_total_nxt   = res_total_r;
    res_st_nxt      = res_st_r;
    off_we          = 1'b0;
    off_re          = 1'b0;
    wi_we           = 1'b0;
    wi_re           = 1'b0;
    off_waddr       = build_cnt_r[IW-1:0];
    off_raddr       = wi_rdata[IW-1:0];
    wi_waddr        = build_cnt_r[IW-1:0];
    wi_wdata        = {gen_weight, build_cnt_r[IW-1:0]};
    wi_raddr        = q_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_off_nxt   = '0;
          res_w_nxt     = '0;
          res_src_nxt   = '0;
          res_total_nxt = count_x[FIELD_W-1:0];
          if (in_ch.action == ACT_BUILD) begin
            if (cfg_bad) begin
              res_st_nxt = ST_BAD_CFG;
              state_nxt  = S_RESP;
            end else begin
              req_nxt       = '{phase: PH_ZERO, a: 6'd0, b: 6'd0};
              build_cnt_nxt = '0;
              state_nxt     = S_GEN;
            end
          end else if (!ready_r || rank_x >= count_x) begin
            res_st_nxt = ST_BAD_RANK;
            state_nxt  = S_RESP;
          end else begin
            wi_re      = 1'b1;
            wi_raddr   = rank_x[IW-1:0];
            res_st_nxt = ST_OK;
            state_nxt  = S_RD_WI;
          end
        end
      end

      // Write one entry a cycle; drop entries past the depth
      S_GEN: begin
        if (build_cnt_r < DEPTH_C) begin
          off_we        = 1'b1;
          wi_we         = 1'b1;
          build_cnt_nxt = build_cnt_r + CW'(1);
        end
        case (req_r.phase)
          PH_ZERO: req_nxt = '{phase: PH_U, a: 6'd0, b: 6'd0};
          PH_U: begin
            if (req_r.a == k_m1) req_nxt = '{phase: PH_V, a: 6'd0, b: 6'd0};
            else req_nxt.a = req_r.a + 6'd1;
          end
          PH_V: begin
            if (req_r.b == m_m1) req_nxt = '{phase: PH_UV, a: 6'd0, b: 6'd0};
            else req_nxt.b = req_r.b + 6'd1;
          end
          PH_UV: begin
            if (req_r.b == m_m1) begin
              req_nxt.b = 6'd0;
              if (req_r.a == k_m1) state_nxt = S_SORT0;
              else req_nxt.a = req_r.a + 6'd1;
            end else begin
              req_nxt.b = req_r.b + 6'd1;
            end
          end
          default: state_nxt = S_SORT0;
        endcase
      end

      S_SORT0: begin
        i_nxt    = '0;
        q_nxt    = '0;
        pend_nxt = 1'b0;
        state_nxt = (build_cnt_r > CW'(1)) ? S_SCAN : S_FIN;
      end

      // Stream entries i..N-1; keep the first minimum
      S_SCAN: begin
        if (pend_r) begin
          if (p_r == i_r) begin
            cur_nxt  = wi_rdata;
            best_nxt = wi_rdata;
            bidx_nxt = i_r;
          end else if (best_r[WW-1:IW] > wi_rdata[WW-1:IW]) begin
            best_nxt = wi_rdata;
            bidx_nxt = p_r;
          end
        end
        if (pend_r && (CW'(p_r) == build_cnt_r - CW'(1))) begin
          pend_nxt  = 1'b0;
          state_nxt = S_SWAP_A;
        end else if (q_r < build_cnt_r) begin
          wi_re    = 1'b1;
          p_nxt    = q_r[IW-1:0];
          pend_nxt = 1'b1;
          q_nxt    = q_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_SWAP_A: begin
        wi_we     = 1'b1;
        wi_waddr  = i_r;
        wi_wdata  = best_r;
        state_nxt = S_SWAP_B;
      end

      S_SWAP_B: begin
        wi_we    = 1'b1;
        wi_waddr = bidx_r;
        wi_wdata = cur_r;
        if (({1'b0, CW'(i_r)} + (CW+1)'(2)) < {1'b0, build_cnt_r}) begin
          i_nxt     = i_r + IW'(1);
          q_nxt     = CW'(i_r) + CW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        entry_count_nxt = build_cnt_r;
        ready_nxt       = 1'b1;
        res_total_nxt   = total_x[FIELD_W-1:0];
        res_st_nxt      = ST_OK;
        state_nxt       = S_RESP;
      end

      S_RD_WI: begin
        off_re    = 1'b1;
        state_nxt = S_RD_OFF;
      end

      S_RD_OFF: begin
        res_off_nxt = off_rdata;
        res_w_nxt   = wi_rdata[WW-1:IW];
        res_src_nxt = src_x[FIELD_W-1:0];
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_off_nxt   = out_off_r;
    out_w_nxt     = out_w_r;
    out_src_nxt   = out_src_r;
    out_total_nxt = out_total_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (state_r == S_RESP && out_free) begin
      out_valid_nxt = 1'b1;
      out_off_nxt   = res_off_r;
      out_w_nxt     = res_w_r;
      out_src_nxt   = res_src_r;
      out_total_nxt = res_total_r;
      out_st_nxt    = res_st_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.offset_value = out_off_r;
  assign out_ch.weight       = out_w_r;
  assign out_ch.source_index = out_src_r;
  assign out_ch.entry_total  = out_total_r;
  assign out_ch.status       = out_st_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      build_cnt_r   <= '0;
      entry_count_r <= '0;
      ready_r       <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      build_cnt_r   <= build_cnt_nxt;
      entry_count_r <= entry_count_nxt;
      ready_r       <= ready_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    i_r         <= i_nxt;
    q_r         <= q_nxt;
    p_r         <= p_nxt;
    best_r      <= best_nxt;
    cur_r       <= cur_nxt;
    bidx_r      <= bidx_nxt;
    res_off_r   <= res_off_nxt;
    res_w_r     <= res_w_nxt;
    res_src_r   <= res_src_nxt;
    res_total_r <= res_total_nxt;
    res_st_r    <= res_st_nxt;
    out_off_r   <= out_off_nxt;
    out_w_r     <= out_w_nxt;
    out_src_r   <= out_src_nxt;
    out_total_r <= out_total_nxt;
    out_st_r    <= out_st_nxt;
  end

  // Offset memory
  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_waddr] <= gen_mask;
    if (off_re) off_rdata <= off_mem[off_raddr];
  end

  // Weight and source index memory
  always_ff @(posedge clk) begin
    if (wi_we) wi_mem[wi_waddr] <= wi_wdata;
    if (wi_re) wi_rdata <= wi_mem[wi_raddr];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= DEPTH_C && build_cnt_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_empty_unbuilt: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> entry_count_r == '0)
    else $error("entries counted with no table built");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP_A |-> best_r[WW-1:IW] <= cur_r[WW-1:IW])
    else $error("selected minimum heavier than current entry");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_RD_WI || state_r == S_RD_OFF) |-> !wi_we && !off_we)
    else $error("memory written while streaming reads");

endmodule
